/* hdl/pba_pkg.sv */
`default_nettype none

package pba_pkg;

  // item field widths
  localparam int unsigned ADDR_W  = 28;
  localparam int unsigned LEN_W   = 29;
  localparam int unsigned COUNT_W = 17;

  // page geometry
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned NUM_PAGES  = 65536;
  localparam int unsigned PAGE_W     = $clog2(NUM_PAGES);

  // bitmap storage: one word holds the used bits of WORD_W pages
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned WORD_IDX_W  = $clog2(WORD_W);
  localparam int unsigned MAP_WORDS   = NUM_PAGES / WORD_W;
  localparam int unsigned MAP_ADDR_W  = $clog2(MAP_WORDS);
  localparam int unsigned POP_W       = WORD_IDX_W + 1;

  // end-of-range sum: byte address plus length plus rounding
  localparam int unsigned SUM_W  = LEN_W + 1;
  localparam int unsigned LAST_W = SUM_W - PAGE_SHIFT;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_RESERVE = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_PAGE = 2'd1,
    STATUS_BEYOND  = 2'd2
  } status_e;

  typedef logic [WORD_W-1:0]     map_word_t;
  typedef logic [MAP_ADDR_W-1:0] map_addr_t;

  // access bundle from the sequencer to the bitmap store
  typedef struct packed {
    logic      re;
    map_addr_t raddr;
    logic      we;
    map_addr_t waddr;
    map_word_t wdata;
  } map_req_t;

endpackage

`default_nettype wire

/* hdl/pba_if.sv */
`default_nettype none

interface pba_req_if;
  import pba_pkg::*;

  logic                 valid;
  logic                 ready;
  kind_e                kind;
  logic [ADDR_W-1:0]    byte_address;
  logic [LEN_W-1:0]     range_length;

  modport source (output valid, output kind, output byte_address, output range_length,
                  input ready);
  modport sink   (input valid, input kind, input byte_address, input range_length,
                  output ready);
endinterface

interface pba_rsp_if;
  import pba_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ADDR_W-1:0]    page_address;
  logic [1:0]           status;
  logic [COUNT_W-1:0]   free_count;

  modport source (output valid, output page_address, output status, output free_count,
                  input ready);
  modport sink   (input valid, input page_address, input status, input free_count,
                  output ready);
endinterface

`default_nettype wire

/* hdl/page_bitmap_allocator_unit.sv */
`default_nettype none

// channel   dir  modport        payload                               transfer when
// req_i     in   pba_req_if     kind, byte_address, range_length      valid & ready
// rsp_o     out  pba_rsp_if     page_address, status, free_count      valid & ready
//
// allocate: n = bitmap words read (1 to 1025), one word
//   per cycle through the single read port of the 1024 x 64 bitmap store
// free: one read-modify-write of a single word; reserve/release range: read-modify-write, then count, per touched word
// after reset a sweep writes all-ones into all 1024 bitmap words; req_i.ready stays low
// one item at a time; req_i.ready is high in idle even while a result waits on rsp_o
// a stalled result sits in a holding stage, the next item waits only at its own result

module page_bitmap_allocator_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  pba_req_if.sink    req_i,
  pba_rsp_if.source  rsp_o
);
  import pba_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_ASCAN = 4'd2;
  localparam logic [3:0] S_AWR   = 4'd3;
  localparam logic [3:0] S_FMOD  = 4'd4;
  localparam logic [3:0] S_RSET  = 4'd5;
  localparam logic [3:0] S_RMOD  = 4'd6;
  localparam logic [3:0] S_RCNT  = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  localparam map_word_t ONES = {WORD_W{1'b1}};

  // lowest set bit of a word
  function automatic logic [WORD_IDX_W-1:0] first_one(input map_word_t w);
    logic [WORD_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = WORD_IDX_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [POP_W-1:0] pop_count(input map_word_t w);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + POP_W'(w[i]);
    end
    return n;
  endfunction

  logic [3:0]               state_q, state_d;
  kind_e                    kind_q, kind_d;
  logic [ADDR_W-1:0]        addr_q, addr_d;
  logic [LEN_W-1:0]         len_q, len_d;

  // architectural state
  logic [COUNT_W-1:0]       free_q, free_d;
  logic [COUNT_W-1:0]       cursor_q, cursor_d;

  // scan / range walk
  map_addr_t                ptr_q, ptr_d;
  logic                     first_q, first_d;
  map_word_t                word_q, word_d;
  map_word_t                hit_q, hit_d;
  logic [COUNT_W-1:0]       last_q, last_d;
  map_addr_t                wlast_q, wlast_d;
  map_word_t                lo_mask_q, lo_mask_d;
  map_word_t                hi_mask_q, hi_mask_d;
  logic [POP_W-1:0]         pop_q, pop_d;

  // finished result, then the output register
  logic [ADDR_W-1:0]        res_addr_q, res_addr_d;
  status_e                  res_status_q, res_status_d;
  logic                     out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]        out_addr_q, out_addr_d;
  status_e                  out_status_q, out_status_d;
  logic [COUNT_W-1:0]       out_count_q, out_count_d;

  map_req_t                 map_req;
  map_word_t                rdata;
  logic                     init_done;

  pba_map_store u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (map_req),
    .rdata_o     (rdata),
    .init_done_o (init_done)
  );

  // page and word of the item's byte address
  logic [PAGE_W-1:0]        first_pg;
  map_addr_t                first_word;
  logic [WORD_IDX_W-1:0]    first_bit;

  assign first_pg   = addr_q[ADDR_W-1:PAGE_SHIFT];
  assign first_word = first_pg[PAGE_W-1:WORD_IDX_W];
  assign first_bit  = first_pg[WORD_IDX_W-1:0];

  // end of range in pages, rounded up for reserve
  logic [SUM_W-1:0]         range_sum;
  logic [LAST_W-1:0]        last_full;

  assign range_sum = SUM_W'(addr_q) + SUM_W'(len_q)
                   + ((kind_q == KIND_RESERVE) ? SUM_W'(PAGE_BYTES - 1) : '0);
  assign last_full = range_sum[SUM_W-1:PAGE_SHIFT];

  // search mask for the first word: skip pages below the cursor
  map_word_t                cur_mask;
  map_word_t                scan_zeros;
  logic [PAGE_W-1:0]        last_pg;
  logic [PAGE_W-1:0]        hit_pg;
  logic [WORD_IDX_W-1:0]    hit_bit;
  map_word_t                range_mask;

  assign cur_mask   = cursor_q[PAGE_W] ? ONES : (ONES << cursor_q[WORD_IDX_W-1:0]);
  assign scan_zeros = ~rdata & (first_q ? cur_mask : ONES);
  assign last_pg    = PAGE_W'(last_q - 1'b1);
  assign hit_bit    = first_one(hit_q);
  assign hit_pg     = {ptr_q, hit_bit};
  assign range_mask = ((ptr_q == first_word) ? lo_mask_q : ONES)
                    & ((ptr_q == wlast_q) ? hi_mask_q : ONES);

  assign req_i.ready = (state_q == S_IDLE) && init_done;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    addr_d       = addr_q;
    len_d        = len_q;
    free_d       = free_q;
    cursor_d     = cursor_q;
    ptr_d        = ptr_q;
    first_d      = first_q;
    word_d       = word_q;
    hit_d        = hit_q;
    last_d       = last_q;
    wlast_d      = wlast_q;
    lo_mask_d    = lo_mask_q;
    hi_mask_d    = hi_mask_q;
    pop_d        = pop_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    map_req      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid && init_done) begin
          kind_d  = req_i.kind;
          addr_d  = req_i.byte_address;
          len_d   = req_i.range_length;
          state_d = S_SETUP;
        end
      end

      S_SETUP: begin
        res_addr_d   = '0;
        res_status_d = STATUS_OK;
        unique case (kind_q)
          KIND_ALLOC: begin
            // an exact count of zero means the scan would find nothing
            if (free_q == '0) begin
              res_status_d = STATUS_NO_PAGE;
              state_d      = S_RESP;
            end else begin
              map_req.re    = 1'b1;
              map_req.raddr = cursor_q[PAGE_W-1:WORD_IDX_W];
              ptr_d         = cursor_q[PAGE_W-1:WORD_IDX_W];
              first_d       = 1'b1;
              state_d       = S_ASCAN;
            end
          end
          KIND_FREE: begin
            if (COUNT_W'(first_pg) >= COUNT_W'(NUM_PAGES)) begin
              res_status_d = STATUS_BEYOND;
              state_d      = S_RESP;
            end else begin
              map_req.re    = 1'b1;
              map_req.raddr = first_word;
              state_d       = S_FMOD;
            end
          end
          KIND_RESERVE, KIND_RELEASE: begin
            // pages past the table are dropped
            if (last_full > LAST_W'(NUM_PAGES)) begin
              last_d = COUNT_W'(NUM_PAGES);
            end else begin
              last_d = COUNT_W'(last_full);
            end
            state_d = S_RSET;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end

      S_ASCAN: begin
        // next word always requested, dropped on a hit; address wraps to word zero
        map_req.re    = 1'b1;
        map_req.raddr = ptr_q + 1'b1;
        if (scan_zeros != '0) begin
          hit_d   = scan_zeros;
          word_d  = rdata;
          state_d = S_AWR;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          first_d = 1'b0;
        end
      end

      S_AWR: begin
        map_req.we    = 1'b1;
        map_req.waddr = ptr_q;
        map_req.wdata = word_q | (map_word_t'(1) << hit_bit);
        free_d        = free_q - 1'b1;
        cursor_d      = COUNT_W'(hit_pg) + 1'b1;
        res_addr_d    = {hit_pg, {PAGE_SHIFT{1'b0}}};
        state_d       = S_RESP;
      end

      S_FMOD: begin
        if (rdata[first_bit]) begin
          map_req.we    = 1'b1;
          map_req.waddr = first_word;
          map_req.wdata = rdata & ~(map_word_t'(1) << first_bit);
          free_d        = free_q + 1'b1;
          // a freed page below the cursor pulls it back
          if (COUNT_W'(first_pg) < cursor_q) begin
            cursor_d = COUNT_W'(first_pg);
          end
        end
        state_d = S_RESP;
      end

      S_RSET: begin
        if (last_q <= COUNT_W'(first_pg)) begin
          // empty or reversed range
          state_d = S_RESP;
        end else begin
          wlast_d       = last_pg[PAGE_W-1:WORD_IDX_W];
          lo_mask_d     = ONES << first_bit;
          hi_mask_d     = ONES >> (~last_pg[WORD_IDX_W-1:0]);
          ptr_d         = first_word;
          map_req.re    = 1'b1;
          map_req.raddr = first_word;
          state_d       = S_RMOD;
        end
      end

      S_RMOD: begin
        map_req.we    = 1'b1;
        map_req.waddr = ptr_q;
        if (kind_q == KIND_RESERVE) begin
          map_req.wdata = rdata | range_mask;
          pop_d         = pop_count(range_mask & ~rdata);
        end else begin
          map_req.wdata = rdata & ~range_mask;
          pop_d         = pop_count(range_mask & rdata);
        end
        state_d = S_RCNT;
      end

      S_RCNT: begin
        if (kind_q == KIND_RESERVE) begin
          free_d = free_q - COUNT_W'(pop_q);
        end else begin
          free_d = free_q + COUNT_W'(pop_q);
        end
        if (ptr_q == wlast_q) begin
          state_d = S_RESP;
        end else begin
          ptr_d         = ptr_q + 1'b1;
          map_req.re    = 1'b1;
          map_req.raddr = ptr_q + 1'b1;
          state_d       = S_RMOD;
        end
      end

      S_RESP: begin
        // hand over once the output register is free or being emptied
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          out_count_d  = free_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_q      <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and scan registers, no reset needed
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    addr_q       <= addr_d;
    len_q        <= len_d;
    ptr_q        <= ptr_d;
    first_q      <= first_d;
    word_q       <= word_d;
    hit_q        <= hit_d;
    last_q       <= last_d;
    wlast_q      <= wlast_d;
    lo_mask_q    <= lo_mask_d;
    hi_mask_q    <= hi_mask_d;
    pop_q        <= pop_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.page_address = out_addr_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.free_count   = out_count_q;

  // free count is an exact page count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= COUNT_W'(NUM_PAGES))
    else $error("free page count above table size");

  // cursor stays within the table or one past its end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= COUNT_W'(NUM_PAGES))
    else $error("search cursor out of range");

  // a scan only runs while some page is free, so it must end in a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ASCAN) |-> (free_q != '0))
    else $error("bitmap scan with no free page");

  // no item taken before the bitmap sweep finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> init_done)
    else $error("item in flight before bitmap init");

  // a successful allocation uses up exactly one free page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AWR) |=> (free_q == $past(free_q) - 1'b1))
    else $error("allocation did not take one page");

endmodule

`default_nettype wire

/* hdl/pba_map_store.sv */
`default_nettype none

module pba_map_store (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  pba_pkg::map_req_t   req_i,
  output pba_pkg::map_word_t  rdata_o,
  output logic                init_done_o
);
  import pba_pkg::*;

  map_word_t mem [MAP_WORDS];

  // sweep counter, top bit set once every word holds all ones
  logic [MAP_ADDR_W:0] clr_q, clr_d;
  logic                sweeping;

  assign sweeping    = !clr_q[MAP_ADDR_W];
  assign init_done_o = clr_q[MAP_ADDR_W];

  always_comb begin
    clr_d = clr_q;
    if (sweeping) begin
      clr_d = clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sweeping) begin
      mem[clr_q[MAP_ADDR_W-1:0]] <= {WORD_W{1'b1}};
    end else if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

`default_nettype wire
